>>> hw/rtl/mpqt_pkg.sv
// ---------------------------------------------------------------------------
// mpqt_pkg
// Shared constants for the unsorted minimum priority queue table.
// ---------------------------------------------------------------------------
`default_nettype none

package mpqt_pkg;

  localparam int MPQT_CAPACITY      = 64;
  localparam int MPQT_TAG_BITS      = 32;
  localparam int MPQT_PRIORITY_BITS = 16;

  localparam int OP_BITS     = 3;
  localparam int STATUS_BITS = 3;

  localparam logic [OP_BITS-1:0] OP_ENQUEUE = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DEQUEUE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_CHANGE  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_PEEK    = 3'd3;
  localparam logic [OP_BITS-1:0] OP_CLEAR   = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY       = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_LESS_URGENT = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_FULL        = 3'd4;

endpackage

`default_nettype wire

>>> hw/rtl/mpqt_ram.sv
// ---------------------------------------------------------------------------
// mpqt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module mpqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/min_priority_queue_table.sv
// ---------------------------------------------------------------------------
// min_priority_queue_table
// Minimum priority queue held in an unsorted table in one RAM. Each entry
// holds a valid bit, a recency rank, a signed priority and a tag.
// ---------------------------------------------------------------------------
//
// Channel  Direction  Contents
// in_*     slave      opcode, value_tag, new_priority
// out_*    master     out_tag, out_priority, entry_count, status
//
// Peek and change scan the whole table once, and change may then write the
// entry back; dequeue then makes a second pass that retires the entry and
// closes the recency ranks. Enqueue scans up to the first free slot; clear
// sweeps every slot, and a like sweep follows reset. Results leave through
// an output register, so the next item is taken while a result still waits.
// ---------------------------------------------------------------------------
`default_nettype none

module min_priority_queue_table
  import mpqt_pkg::*;
#(
  parameter int CAPACITY      = MPQT_CAPACITY,
  parameter int TAG_BITS      = MPQT_TAG_BITS,
  parameter int PRIORITY_BITS = MPQT_PRIORITY_BITS,
  localparam int CW     = $clog2(CAPACITY + 1),
  localparam int IN_RAW = OP_BITS + TAG_BITS + PRIORITY_BITS,
  localparam int IN_W   = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW = TAG_BITS + PRIORITY_BITS + CW + STATUS_BITS,
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // opcode, value_tag, new_priority (from bit 0 up), zero padded
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // out_tag, out_priority, entry_count, status (from bit 0 up), zero padded
  output logic      [OUT_W-1:0] out_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = 1 + AW + PRIORITY_BITS + TAG_BITS;
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL = CW'(CAPACITY);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic clr_op_r, clr_op_nxt;
  logic [OP_BITS-1:0] op_r, op_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic signed [PRIORITY_BITS-1:0] pri_r, pri_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic rd_on_r, rd_on_nxt;
  logic rv_r;
  logic [AW-1:0] ra_r;
  logic fnd_r, fnd_nxt;
  logic [AW-1:0] b_idx_r, b_idx_nxt;
  logic [TAG_BITS-1:0] b_tag_r, b_tag_nxt;
  logic signed [PRIORITY_BITS-1:0] b_pri_r, b_pri_nxt;
  logic [AW-1:0] b_rec_r, b_rec_nxt;
  logic [TAG_BITS-1:0] res_tag_r, res_tag_nxt;
  logic signed [PRIORITY_BITS-1:0] res_pri_r, res_pri_nxt;
  logic [STATUS_BITS-1:0] res_st_r, res_st_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;

  logic we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rd_data;

  logic [OP_BITS-1:0] in_op;
  logic [TAG_BITS-1:0] in_tag;
  logic signed [PRIORITY_BITS-1:0] in_pri;
  logic in_xfer;

  logic d_v;
  logic [AW-1:0] d_rec;
  logic signed [PRIORITY_BITS-1:0] d_pri;
  logic [TAG_BITS-1:0] d_tag;
  logic upd;

  assign in_op   = in_tdata[OP_BITS-1:0];
  assign in_tag  = in_tdata[OP_BITS +: TAG_BITS];
  assign in_pri  = in_tdata[OP_BITS + TAG_BITS +: PRIORITY_BITS];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer = in_tvalid && in_tready;

  assign d_tag = rd_data[TAG_BITS-1:0];
  assign d_pri = rd_data[TAG_BITS +: PRIORITY_BITS];
  assign d_rec = rd_data[TAG_BITS + PRIORITY_BITS +: AW];
  assign d_v   = rd_data[EW-1];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  mpqt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_on_r),
    .raddr (rd_addr_r),
    .rdata (rd_data)
  );

  always_comb begin
    upd = 1'b0;
    if (op_r == OP_CHANGE) begin
      upd = d_v && (d_tag == tag_r) && (!fnd_r || (d_rec > b_rec_r));
    end else begin
      upd = d_v && (!fnd_r || (d_pri < b_pri_r) ||
                    ((d_pri == b_pri_r) && (d_rec > b_rec_r)));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_op_nxt    = clr_op_r;
    op_nxt        = op_r;
    tag_nxt       = tag_r;
    pri_nxt       = pri_r;
    cnt_nxt       = cnt_r;
    rd_addr_nxt   = rd_addr_r;
    rd_on_nxt     = rd_on_r;
    fnd_nxt       = fnd_r;
    b_idx_nxt     = b_idx_r;
    b_tag_nxt     = b_tag_r;
    b_pri_nxt     = b_pri_r;
    b_rec_nxt     = b_rec_r;
    res_tag_nxt   = res_tag_r;
    res_pri_nxt   = res_pri_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    we    = 1'b0;
    waddr = ra_r;
    wdata = '0;

    if (rd_on_r) begin
      rd_addr_nxt = rd_addr_r + AW'(1);
      if (rd_addr_r == LAST) begin
        rd_on_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_CLR: begin
        we    = 1'b1;
        waddr = rd_addr_r;
        wdata = '0;
        rd_addr_nxt = rd_addr_r + AW'(1);
        if (rd_addr_r == LAST) begin
          rd_addr_nxt = '0;
          state_nxt   = clr_op_r ? S_FIN : S_IDLE;
          clr_op_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt      = in_op;
          tag_nxt     = in_tag;
          pri_nxt     = in_pri;
          res_tag_nxt = '0;
          res_pri_nxt = '0;
          res_st_nxt  = ST_OK;
          fnd_nxt     = 1'b0;
          rd_addr_nxt = '0;
          state_nxt   = S_FIN;
          priority if (in_op == OP_CLEAR) begin
            cnt_nxt    = '0;
            clr_op_nxt = 1'b1;
            state_nxt  = S_CLR;
          end else if (in_op == OP_ENQUEUE) begin
            if (cnt_r >= FULL) begin
              res_st_nxt = ST_FULL;
            end else begin
              rd_on_nxt = 1'b1;
              state_nxt = S_SCAN;
            end
          end else if (in_op == OP_DEQUEUE || in_op == OP_PEEK ||
                       in_op == OP_CHANGE) begin
            if (cnt_r == '0) begin
              res_st_nxt = (in_op == OP_CHANGE) ? ST_NOT_FOUND : ST_EMPTY;
            end else begin
              rd_on_nxt = 1'b1;
              state_nxt = S_SCAN;
            end
          end else begin
            res_st_nxt = ST_OK;
          end
        end
      end
      S_SCAN: begin
        if (rv_r) begin
          if (op_r == OP_ENQUEUE) begin
            if (!d_v) begin
              we        = 1'b1;
              waddr     = ra_r;
              wdata     = {1'b1, cnt_r[AW-1:0], pri_r, tag_r};
              cnt_nxt   = cnt_r + CW'(1);
              rd_on_nxt = 1'b0;
              state_nxt = S_FIN;
            end
          end else begin
            if (upd) begin
              fnd_nxt   = 1'b1;
              b_idx_nxt = ra_r;
              b_tag_nxt = d_tag;
              b_pri_nxt = d_pri;
              b_rec_nxt = d_rec;
            end
            if (ra_r == LAST) begin
              if (op_r == OP_CHANGE) begin
                priority if (!fnd_nxt) begin
                  res_st_nxt = ST_NOT_FOUND;
                  state_nxt  = S_FIN;
                end else if (b_pri_nxt < pri_r) begin
                  res_st_nxt = ST_LESS_URGENT;
                  state_nxt  = S_FIN;
                end else begin
                  state_nxt = S_WR;
                end
              end else begin
                res_tag_nxt = b_tag_nxt;
                res_pri_nxt = b_pri_nxt;
                if (op_r == OP_DEQUEUE) begin
                  rd_addr_nxt = '0;
                  rd_on_nxt   = 1'b1;
                  state_nxt   = S_DEC;
                end else begin
                  state_nxt = S_FIN;
                end
              end
            end
          end
        end
      end
      S_DEC: begin
        if (rv_r) begin
          waddr = ra_r;
          if (ra_r == b_idx_r) begin
            we    = 1'b1;
            wdata = {1'b0, d_rec, d_pri, d_tag};
          end else if (d_v && (d_rec > b_rec_r)) begin
            we    = 1'b1;
            wdata = {1'b1, d_rec - AW'(1), d_pri, d_tag};
          end
          if (ra_r == LAST) begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_FIN;
          end
        end
      end
      S_WR: begin
        we        = 1'b1;
        waddr     = b_idx_r;
        wdata     = {1'b1, b_rec_r, pri_r, b_tag_r};
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = OUT_W'({res_st_r, cnt_r, res_pri_r, res_tag_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_op_r    <= 1'b0;
      cnt_r       <= '0;
      rd_addr_r   <= '0;
      rd_on_r     <= 1'b0;
      rv_r        <= 1'b0;
      fnd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_op_r    <= clr_op_nxt;
      cnt_r       <= cnt_nxt;
      rd_addr_r   <= rd_addr_nxt;
      rd_on_r     <= rd_on_nxt;
      rv_r        <= rd_on_r;
      fnd_r       <= fnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    tag_r       <= tag_nxt;
    pri_r       <= pri_nxt;
    ra_r        <= rd_addr_r;
    b_idx_r     <= b_idx_nxt;
    b_tag_r     <= b_tag_nxt;
    b_pri_r     <= b_pri_nxt;
    b_rec_r     <= b_rec_nxt;
    res_tag_r   <= res_tag_nxt;
    res_pri_r   <= res_pri_nxt;
    res_st_r    <= res_st_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

`default_nettype wire
